FILE: rtl/moving_average_noise_gate_top_assert.svh
// Assertion macros used by the moving-average noise gate top level.
`ifndef MOVING_AVERAGE_NOISE_GATE_TOP_ASSERT_SVH
`define MOVING_AVERAGE_NOISE_GATE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MANG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MANG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mang_pkg.sv
// Types and fixed constants of the moving-average noise gate.
package mang_pkg;

   localparam int SAMPLE_W = 10;
   localparam int SUM_W    = 14;
   localparam int NOISE_W  = 16;
   // Width of the difference sum times one hundred.
   localparam int NUM_W    = 21;
   localparam int DIV_CNT_W = 5;

   localparam logic [6:0]         PERCENT     = 7'd100;
   localparam logic [NOISE_W-1:0] NOISE_MAX   = 16'hFFFF;
   localparam logic [NOISE_W-1:0] LIMIT_RESET = 16'd100;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'h3FF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_OLDEST,
      ST_RD_OLDER,
      ST_RD_PREV,
      ST_SUM,
      ST_AVG,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: rtl/mang_ring.sv
// Sample ring memory with one write port, one registered read port and per-entry valid bits.
module mang_ring #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [mang_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [mang_pkg::SAMPLE_W-1:0] rd_data
);

   logic [mang_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]              valid_ff;
   logic [mang_pkg::SAMPLE_W-1:0] rdata_ff;
   logic                          rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

FILE: rtl/mang_div.sv
// Restoring divider, one quotient bit per cycle, for the noise ratio.
module mang_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mang_pkg::NUM_W-1:0]   numer,
   input  logic [mang_pkg::SUM_W-1:0]   denom,
   output logic [mang_pkg::NUM_W-1:0]   quot,
   output mang_pkg::div_stat_type       stat
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [mang_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [mang_pkg::SUM_W-1:0]     rem_ff, rem_in;
   logic [mang_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [mang_pkg::SUM_W-1:0]     den_ff, den_in;
   logic [mang_pkg::SUM_W:0]       trial;
   logic [mang_pkg::SUM_W:0]       diff;
   logic                           fits;

   // A zero divisor always fits, which leaves an all-ones quotient.
   always_comb begin
      trial = {rem_ff, quo_ff[mang_pkg::NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? diff[mang_pkg::SUM_W-1:0] : trial[mang_pkg::SUM_W-1:0];
         quo_in = {quo_ff[mang_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mang_pkg::DIV_CNT_W'(mang_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/moving_average_noise_gate_top.sv
// Moving-average noise gate top level: control sequencer, running sums and result register.
// Each accepted sample is written into a ring memory; three earlier samples are then read back
// one per cycle through the memory's single registered read port, the sample and difference
// sums are updated, the average comes from a reciprocal multiply, and the noise percentage
// from a 21-step bit-serial divider. Most of an item's time from acceptance until its result
// is offered is spent in the divider, and the next item is accepted once the sequencer
// returns to idle, which it does as soon as the result register is free. While a result
// waits to be taken, the next item is still accepted. The ring starts out reading as all
// zeros after reset, with no clearing pass. The noise limit register resets to 100 and is
// written with csr_wr_en.
module moving_average_noise_gate_top #(
   parameter int AVG_COUNT  = 8,
   parameter int RING_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: sample [9:0], zero padding [15:10].
   input  logic [15:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: distance [9:0], average [19:10], noise_percent [35:20], padding [39:36].
   output logic [39:0] rsp_tdata,
   // rsp_tuser: too_noisy [0].
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   `include "moving_average_noise_gate_top_assert.svh"

   localparam int AW = $clog2(RING_DEPTH);
   localparam int OFF_OLDEST = (RING_DEPTH - (AVG_COUNT % RING_DEPTH)) % RING_DEPTH;
   localparam int OFF_OLDER  = (RING_DEPTH - ((AVG_COUNT + 1) % RING_DEPTH)) % RING_DEPTH;
   localparam int OFF_PREV   = RING_DEPTH - 1;
   // Exact floor division of a 14-bit sum by AVG_COUNT via a rounded-up reciprocal.
   localparam int AVG_SHIFT  = mang_pkg::SUM_W + $clog2(AVG_COUNT);
   localparam int MUL_W      = mang_pkg::SUM_W + 1;
   localparam logic [MUL_W-1:0] AVG_MUL =
      MUL_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

   mang_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                 slot_ff, slot_in;
   logic [mang_pkg::SAMPLE_W-1:0] sample_ff;
   logic [mang_pkg::SAMPLE_W-1:0] oldest_ff;
   logic [mang_pkg::SAMPLE_W-1:0] older_ff;
   logic [mang_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [mang_pkg::SUM_W-1:0]    step_ff, step_in;
   logic [mang_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic [mang_pkg::NOISE_W-1:0]  limit_ff;
   logic [39:0]                   rsp_tdata_ff;
   logic                          rsp_tuser_ff;
   logic                          rsp_tvalid_ff;

   logic                          accept;
   logic                          out_free;
   logic                          ring_rd_en;
   logic [AW-1:0]                 ring_rd_addr;
   logic [mang_pkg::SAMPLE_W-1:0] ring_rd_data;
   logic                          div_start;
   logic                          load_out;
   logic [mang_pkg::NUM_W-1:0]    div_numer;
   logic [mang_pkg::NUM_W-1:0]    div_quot;
   mang_pkg::div_stat_type        div_stat;

   logic [mang_pkg::SAMPLE_W-1:0] diff_last, diff_new;
   logic [mang_pkg::SUM_W+MUL_W-1:0] avg_prod;
   logic [mang_pkg::SUM_W-1:0]    avg_full;
   logic [mang_pkg::NOISE_W-1:0]  noise;
   logic                          noisy;

   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] slot, input int off);
      logic [AW:0] pos;
      pos = {1'b0, slot} + (AW+1)'(off);
      if (pos >= (AW+1)'(RING_DEPTH)) begin
         pos = pos - (AW+1)'(RING_DEPTH);
      end
      return pos[AW-1:0];
   endfunction

   function automatic logic [mang_pkg::SAMPLE_W-1:0] abs_diff(
      input logic [mang_pkg::SAMPLE_W-1:0] a,
      input logic [mang_pkg::SAMPLE_W-1:0] b
   );
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   mang_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_tdata[mang_pkg::SAMPLE_W-1:0]),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   mang_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (sum_ff),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mang_pkg::ST_IDLE:      if (req_tvalid) state_in = mang_pkg::ST_RD_OLDEST;
         mang_pkg::ST_RD_OLDEST: state_in = mang_pkg::ST_RD_OLDER;
         mang_pkg::ST_RD_OLDER:  state_in = mang_pkg::ST_RD_PREV;
         mang_pkg::ST_RD_PREV:   state_in = mang_pkg::ST_SUM;
         mang_pkg::ST_SUM:       state_in = mang_pkg::ST_AVG;
         mang_pkg::ST_AVG:       state_in = mang_pkg::ST_DIV;
         mang_pkg::ST_DIV:       if (div_stat.done) state_in = mang_pkg::ST_OUT;
         mang_pkg::ST_OUT:       if (out_free) state_in = mang_pkg::ST_IDLE;
         default:                state_in = mang_pkg::ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready   = 1'b0;
      ring_rd_en   = 1'b0;
      ring_rd_addr = slot_ff;
      div_start    = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         mang_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         mang_pkg::ST_RD_OLDEST: begin
            ring_rd_en   = 1'b1;
            ring_rd_addr = ring_pos(slot_ff, OFF_OLDEST);
         end
         mang_pkg::ST_RD_OLDER: begin
            ring_rd_en   = 1'b1;
            ring_rd_addr = ring_pos(slot_ff, OFF_OLDER);
         end
         mang_pkg::ST_RD_PREV: begin
            ring_rd_en   = 1'b1;
            ring_rd_addr = ring_pos(slot_ff, OFF_PREV);
         end
         mang_pkg::ST_AVG: begin
            div_start = 1'b1;
         end
         mang_pkg::ST_OUT: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   // Running sums wrap at 14 bits; the previous sample arrives from the memory in ST_SUM.
   always_comb begin
      diff_last = abs_diff(oldest_ff, older_ff);
      diff_new  = abs_diff(sample_ff, ring_rd_data);
      sum_in    = sum_ff + mang_pkg::SUM_W'(sample_ff) - mang_pkg::SUM_W'(oldest_ff);
      step_in   = step_ff + mang_pkg::SUM_W'(diff_new) - mang_pkg::SUM_W'(diff_last);
      slot_in   = ring_pos(slot_ff, 1);
   end

   always_comb begin
      avg_prod  = (mang_pkg::SUM_W+MUL_W)'(sum_ff) * (mang_pkg::SUM_W+MUL_W)'(AVG_MUL);
      avg_full  = mang_pkg::SUM_W'(avg_prod >> AVG_SHIFT);
      avg_in    = (avg_full > mang_pkg::SUM_W'(mang_pkg::SAMPLE_MAX)) ? mang_pkg::SAMPLE_MAX
                                                                      : avg_full[9:0];
      div_numer = mang_pkg::NUM_W'(step_ff) * mang_pkg::NUM_W'(mang_pkg::PERCENT);
   end

   always_comb begin
      if (sum_ff == '0 || div_quot > mang_pkg::NUM_W'(mang_pkg::NOISE_MAX)) begin
         noise = mang_pkg::NOISE_MAX;
      end else begin
         noise = div_quot[mang_pkg::NOISE_W-1:0];
      end
      noisy = noise > limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mang_pkg::ST_IDLE;
         slot_ff       <= '0;
         sum_ff        <= '0;
         step_ff       <= '0;
         limit_ff      <= mang_pkg::LIMIT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == mang_pkg::ST_SUM) begin
            sum_ff  <= sum_in;
            step_ff <= step_in;
            slot_ff <= slot_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_tdata[mang_pkg::SAMPLE_W-1:0];
      end
      if (state_ff == mang_pkg::ST_RD_OLDER) begin
         oldest_ff <= ring_rd_data;
      end
      if (state_ff == mang_pkg::ST_RD_PREV) begin
         older_ff <= ring_rd_data;
      end
      if (state_ff == mang_pkg::ST_AVG) begin
         avg_ff <= avg_in;
      end
      if (load_out) begin
         rsp_tdata_ff <= {4'b0, noise, avg_ff,
                          (noisy ? {mang_pkg::SAMPLE_W{1'b0}} : avg_ff)};
         rsp_tuser_ff <= noisy;
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   `MANG_ASSERT_NEXT(a_accept_starts_reads, clock, reset, accept,
      state_ff == mang_pkg::ST_RD_OLDEST, "accepted item did not start the ring reads")
   `MANG_ASSERT_SAME(a_div_done_in_wait, clock, reset, div_stat.done,
      state_ff == mang_pkg::ST_DIV, "divider finished outside its wait state")
   `MANG_ASSERT_SAME(a_div_start_idle, clock, reset, div_start,
      !div_stat.busy, "divider started while still busy")
   `MANG_ASSERT_SAME(a_noisy_gates_distance, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[9:0] == 10'd0, "noisy result carries a nonzero distance")

endmodule
